### rtl/ubd_pkg.sv
// Shared constants, codes and control types for the base digit converter.
package ubd_pkg;

   localparam int VALUE_W        = 64;
   localparam int CHAR_W         = 8;
   localparam int SLOT_COUNT     = 16;
   localparam int DIGIT_W        = $clog2(SLOT_COUNT);
   localparam int MAX_BASE       = 16;
   localparam int BASE_W         = 5;
   localparam int MAX_DIGITS     = 64;
   localparam int CNT_W          = $clog2(MAX_DIGITS);
   localparam int BITS_PER_CYCLE = 8;
   localparam int DIV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
   localparam int STEP_W         = $clog2(DIV_CYCLES);
   localparam int CSR_W          = 64;
   localparam int CSR_IDX_W      = 2;

   localparam logic [CHAR_W-1:0] SIGN_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] SIGN_MINUS = 8'h2D;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_LENGTH = 2'd0,
      CSR_DIGITS_LOW  = 2'd1,
      CSR_DIGITS_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_SEND
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic store_digit;
      logic read_en;
      logic ptr_dec;
   } ubd_cmd_type;

   typedef struct packed {
      logic radix_ok;
      logic div_last;
      logic quot_zero;
      logic cnt_last;
      logic ptr_zero;
   } ubd_status_type;

endpackage

### rtl/ubd_if.sv
// Request and response channel interfaces of the base digit converter.
interface ubd_req_if import ubd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface ubd_rsp_if import ubd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last_digit;

   modport source (output valid, output character, output last_digit, input ready);
   modport sink (input valid, input character, input last_digit, output ready);
endinterface

### rtl/ubd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ubd_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ubd_ctrl.sv
// Controller state machine that sequences division, digit storage and output.
module ubd_ctrl import ubd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  ubd_status_type status,
   output ubd_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.radix_ok) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               cmd.store_digit = 1'b1;
               if (status.quot_zero || status.cnt_last) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.read_en = 1'b1;
            state_in    = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.ptr_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.ptr_dec = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A request under an invalid radix produces no response and leaves the block idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && !status.radix_ok) |=> state_ff == ST_IDLE)
      else $error("invalid radix request did not return to idle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && rsp_ready && status.ptr_zero) |=> state_ff == ST_IDLE)
      else $error("last digit delivered without returning to idle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && !status.div_last) |=> state_ff == ST_DIVIDE)
      else $error("division left before its last step");

endmodule

### rtl/ubd_dpath.sv
// Datapath: configuration registers, radix check, digit divider and digit store.
module ubd_dpath import ubd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   input  logic [VALUE_W-1:0]   req_value,
   input  ubd_cmd_type          cmd,
   output ubd_status_type       status,
   output logic [CHAR_W-1:0]    rsp_character,
   output logic                 rsp_last_digit
);

   logic [BASE_W-1:0]  base_length_ff;
   logic [CSR_W-1:0]   digits_low_ff;
   logic [CSR_W-1:0]   digits_high_ff;

   logic [VALUE_W-1:0] work_ff;
   logic [VALUE_W-1:0] work_in;
   logic [DIGIT_W-1:0] rem_ff;
   logic [DIGIT_W-1:0] rem_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [CNT_W-1:0]   ptr_ff;
   logic [CNT_W-1:0]   ptr_in;

   logic [CHAR_W-1:0]  slot [SLOT_COUNT];
   logic               radix_ok;
   logic [VALUE_W-1:0] div_work;
   logic [DIGIT_W-1:0] div_rem;
   logic [BASE_W-1:0]  acc;
   logic               qbit;
   logic [DIGIT_W-1:0] rd_digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff <= '0;
         digits_low_ff  <= '0;
         digits_high_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE_LENGTH: base_length_ff <= csr_write_data[BASE_W-1:0];
            CSR_DIGITS_LOW:  digits_low_ff  <= csr_write_data;
            CSR_DIGITS_HIGH: digits_high_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < SLOT_COUNT / 2; i++) begin
         slot[i]                  = digits_low_ff[i*CHAR_W +: CHAR_W];
         slot[i + SLOT_COUNT / 2] = digits_high_ff[i*CHAR_W +: CHAR_W];
      end
   end

   // The radix needs at least two distinct characters in use, none of them a sign.
   always_comb begin
      radix_ok = (base_length_ff >= BASE_W'(2)) && (base_length_ff <= BASE_W'(MAX_BASE));
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (BASE_W'(i) < base_length_ff) begin
            if (slot[i] == SIGN_PLUS || slot[i] == SIGN_MINUS) begin
               radix_ok = 1'b0;
            end
            for (int j = i + 1; j < SLOT_COUNT; j++) begin
               if (BASE_W'(j) < base_length_ff && slot[i] == slot[j]) begin
                  radix_ok = 1'b0;
               end
            end
         end
      end
   end

   // Restoring division by the radix, several quotient bits per cycle.
   always_comb begin
      div_work = work_ff;
      div_rem  = rem_ff;
      acc      = '0;
      qbit     = 1'b0;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         acc  = {div_rem, div_work[VALUE_W-1]};
         qbit = (acc >= base_length_ff);
         if (qbit) begin
            acc = acc - base_length_ff;
         end
         div_work = {div_work[VALUE_W-2:0], qbit};
         div_rem  = acc[DIGIT_W-1:0];
      end
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      cnt_in  = cnt_ff;
      ptr_in  = ptr_ff;
      if (cmd.load) begin
         work_in = req_value;
         rem_in  = '0;
         step_in = '0;
         cnt_in  = '0;
      end else if (cmd.div_step) begin
         work_in = div_work;
         step_in = step_ff + STEP_W'(1);
         if (cmd.store_digit) begin
            rem_in = '0;
            cnt_in = cnt_ff + CNT_W'(1);
            ptr_in = cnt_ff;
         end else begin
            rem_in = div_rem;
         end
      end
      if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      cnt_ff  <= cnt_in;
      ptr_ff  <= ptr_in;
   end

   ubd_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (cmd.store_digit),
      .wr_addr (cnt_ff),
      .wr_data (div_rem),
      .rd_en   (cmd.read_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_digit)
   );

   assign status.radix_ok  = radix_ok;
   assign status.div_last  = (step_ff == STEP_W'(DIV_CYCLES - 1));
   assign status.quot_zero = (div_work == '0);
   assign status.cnt_last  = (cnt_ff == CNT_W'(MAX_DIGITS - 1));
   assign status.ptr_zero  = (ptr_ff == '0);

   assign rsp_character  = slot[rd_digit];
   assign rsp_last_digit = (ptr_ff == '0);

   assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && !cmd.store_digit && !cmd.load) |=> $stable(cnt_ff))
      else $error("digit count moved in the middle of a division");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cnt_ff == '0 && step_ff == '0 && rem_ff == '0))
      else $error("new request did not clear the divider");

   assert property (@(posedge clock) disable iff (reset)
      cmd.store_digit |=> ptr_ff == $past(cnt_ff))
      else $error("read pointer not aimed at the newest digit");

endmodule

### rtl/unsigned_to_base_digits_core.sv
// Top level of the unsigned value to base digit characters converter.
//
//   channel   direction  payload                         handshake
//   req_chan  in         value[63:0]                     valid / ready
//   rsp_chan  out        character[7:0], last_digit      valid / ready
//   csr       in         csr_index[1:0], csr_write_data  csr_write_enable
//
// A request is accepted while idle; the divider then forms each digit in turn, which
// retires 8 quotient bits a cycle, and each character then takes a registered
// digit RAM read and the response.
// A request under an invalid radix is consumed with no response.
// Reset clears the configuration registers to zero, which is an invalid radix until written.
// A stalled response holds the block; one request is in flight at a time.
module unsigned_to_base_digits_core import ubd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ubd_req_if.sink              req_chan,
   ubd_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   ubd_cmd_type    cmd;
   ubd_status_type status;

   ubd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ubd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_value        (req_chan.value),
      .cmd              (cmd),
      .status           (status),
      .rsp_character    (rsp_chan.character),
      .rsp_last_digit   (rsp_chan.last_digit)
   );

endmodule
